/* design/shs_pkg.sv */
`default_nettype none
package shs_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam t_word PAD_WORD = 32'h8000_0000;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] FULL_BYTES = 3'd4;

    localparam t_word INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic push;
        logic step;
        logic extend;
    } t_sched_ctl;

    typedef struct packed {
        logic init;
        logic step;
        logic fold;
        logic rearm;
    } t_round_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

/* design/shs_sched.sv */
`default_nettype none
module shs_sched (
    input  wire logic               i_clk,
    input  wire shs_pkg::t_sched_ctl i_ctl,
    input  wire shs_pkg::t_word     i_push_word,
    output shs_pkg::t_word          o_w
);
    import shs_pkg::*;

    // r_win[0] is the oldest word, r_win[15] the newest
    t_word r_win [BLOCK_WORDS];
    t_word n_w;
    t_word shift_in;

    always_comb begin
        if (i_ctl.extend) begin
            n_w = ssig1(r_win[14]) + r_win[9] + ssig0(r_win[1]) + r_win[0];
        end else begin
            // first sixteen rounds rotate the loaded words through
            n_w = r_win[0];
        end
        shift_in = i_ctl.push ? i_push_word : n_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.step) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[BLOCK_WORDS - 1] <= shift_in;
        end
    end

    assign o_w = n_w;

endmodule
`default_nettype wire

/* design/shs_round.sv */
`default_nettype none
module shs_round (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire shs_pkg::t_round_ctl i_ctl,
    input  wire shs_pkg::t_word      i_k,
    input  wire shs_pkg::t_word      i_w,
    output shs_pkg::t_word           o_chain [shs_pkg::DIGEST_WORDS]
);
    import shs_pkg::*;

    t_word r_chain [DIGEST_WORDS];
    t_word r_wv [DIGEST_WORDS];
    t_word t1;
    t_word t2;

    always_comb begin
        t1 = r_wv[7] + bsig1(r_wv[4]) + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
           + i_k + i_w;
        t2 = bsig0(r_wv[0])
           + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_wv <= r_chain;
        end else if (i_ctl.step) begin
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.rearm) begin
            r_chain <= INIT_HASH;
        end else if (i_ctl.fold) begin
            for (int k = 0; k < DIGEST_WORDS; k++) begin
                r_chain[k] <= r_chain[k] + r_wv[k];
            end
        end
    end

    assign o_chain = r_chain;

endmodule
`default_nettype wire

/* design/sha256_stream_hasher_top.sv */
`default_nettype none
// Channel  | Handshake           | Beat fields
// ---------+---------------------+---------------------------------------------
// input    | i_valid / o_ready   | i_message_word, i_valid_bytes, i_last_word
// output   | o_valid / i_ready   | o_digest_word, o_digest_index, o_digest_last
//
// Each accepted message word enters the schedule; the word that completes a
// 16-word block adds 64 rounds and one fold in the shared round unit (one round
// per cycle). The last word then pushes pad words one per cycle, with one or
// two further compressions, before eight digest beats. o_ready is high only
// when idle. Synchronous active-low reset restores the initial hash words,
// clears the word count and the bit length.
module sha256_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_message_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);
    import shs_pkg::*;

    t_state      r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_need80, n_need80;
    logic        r_hi_done, n_hi_done;
    logic        r_done, n_done;
    logic        r_padding, n_padding;

    t_sched_ctl  sched_ctl;
    t_round_ctl  round_ctl;
    t_word       push_word;
    t_word       sched_w;
    t_word       chain [DIGEST_WORDS];
    logic [2:0]  nb_sat;
    t_word       first_pad;

    shs_sched u_sched (
        .i_clk       (i_clk),
        .i_ctl       (sched_ctl),
        .i_push_word (push_word),
        .o_w         (sched_w)
    );

    shs_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_k     (ROUND_K[r_round]),
        .i_w     (sched_w),
        .o_chain (chain)
    );

    always_comb begin
        nb_sat = (i_valid_bytes > FULL_BYTES) ? FULL_BYTES : i_valid_bytes;
        unique case (nb_sat)
            3'd0:    first_pad = PAD_WORD;
            3'd1:    first_pad = {i_message_word[31:24], PAD_BYTE, 16'h0000};
            3'd2:    first_pad = {i_message_word[31:16], PAD_BYTE, 8'h00};
            3'd3:    first_pad = {i_message_word[31:8], PAD_BYTE};
            default: first_pad = i_message_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_len     <= '0;
            r_round   <= '0;
            r_oidx    <= '0;
            r_need80  <= 1'b0;
            r_hi_done <= 1'b0;
            r_done    <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_round   <= n_round;
            r_oidx    <= n_oidx;
            r_need80  <= n_need80;
            r_hi_done <= n_hi_done;
            r_done    <= n_done;
            r_padding <= n_padding;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_round   = r_round;
        n_oidx    = r_oidx;
        n_need80  = r_need80;
        n_hi_done = r_hi_done;
        n_done    = r_done;
        n_padding = r_padding;
        sched_ctl = '0;
        round_ctl = '0;
        push_word = '0;
        o_ready   = (r_state == ST_IDLE);
        o_valid   = (r_state == ST_OUT);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    sched_ctl.push = 1'b1;
                    n_cnt = r_cnt + 4'd1;
                    if (i_last_word) begin
                        n_len     = r_len + {58'd0, nb_sat, 3'b000};
                        n_need80  = (nb_sat == FULL_BYTES);
                        n_padding = 1'b1;
                        push_word = first_pad;
                    end else begin
                        n_len     = r_len + 64'd32;
                        push_word = i_message_word;
                    end
                    if (r_cnt == 4'd15) begin
                        round_ctl.init = 1'b1;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end else if (i_last_word) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctl.push = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_need80) begin
                    push_word = PAD_WORD;
                    n_need80 = 1'b0;
                end else if (r_cnt == 4'd14) begin
                    push_word = r_len[63:32];
                    n_hi_done = 1'b1;
                end else if (r_cnt == 4'd15 && r_hi_done) begin
                    push_word = r_len[31:0];
                    n_done = 1'b1;
                end else begin
                    push_word = '0;
                end
                if (r_cnt == 4'd15) begin
                    round_ctl.init = 1'b1;
                    n_round = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                sched_ctl.step   = 1'b1;
                sched_ctl.extend = (r_round[5:4] != 2'b00);
                round_ctl.step   = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                round_ctl.fold = 1'b1;
                if (r_done) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'(DIGEST_WORDS - 1)) begin
                        round_ctl.rearm = 1'b1;
                        n_cnt     = '0;
                        n_len     = '0;
                        n_need80  = 1'b0;
                        n_hi_done = 1'b0;
                        n_done    = 1'b0;
                        n_padding = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_digest_word  = chain[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 3'(DIGEST_WORDS - 1));

endmodule
`default_nettype wire

/* dv/sha256_stream_hasher_checker.sv */
`default_nettype none
module sha256_stream_hasher_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_message_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_digest_index,
    input  wire logic        i_digest_last,
    output int               o_mismatches,
    output int               o_digests_pending,
    output int               o_digests_checked
);
    import shs_pkg::*;

    localparam t_word SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    t_word        chain_h [8];
    t_word        sched_w [16];
    logic [3:0]   fill_count;
    logic [63:0]  bit_len;
    t_digest_beat expected_digest_q [$];
    int           errs = 0;
    int           checked = 0;

    function automatic t_word rot_right(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void fold_block();
        t_word a, b, c, d, e, f, g, h;
        t_word w, t1, t2, s0, s1, x2, x15;
        int    j;
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (j = 0; j < 64; j++) begin
            if (j < 16) begin
                w = sched_w[j];
            end else begin
                x2  = sched_w[(j - 2) & 15];
                x15 = sched_w[(j - 15) & 15];
                s1 = rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10);
                s0 = rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3);
                w = s1 + sched_w[(j - 7) & 15] + s0 + sched_w[j & 15];
                sched_w[j & 15] = w;
            end
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
               + ((e & f) ^ (~e & g)) + SHA_K[j] + w;
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void push_word(input t_word w);
        sched_w[fill_count] = w;
        fill_count = fill_count + 4'd1;
        if (fill_count == 4'd0)
            fold_block();
    endfunction

    function automatic void restart_message();
        int k;
        for (k = 0; k < 8; k++)
            chain_h[k] = SHA_H0[k];
        fill_count = 4'd0;
        bit_len = 64'd0;
    endfunction

    // Absorb one input beat; on the final word pad, finish and queue the digest.
    function automatic void absorb_word(input t_word word, input logic [2:0] vb,
                                        input logic last);
        int           nb;
        int           k;
        t_word        keep;
        t_digest_beat beat;
        if (!last) begin
            bit_len = bit_len + 64'd32;
            push_word(word);
            return;
        end
        nb = (vb > 3'd4) ? 4 : int'(vb);
        bit_len = bit_len + 64'(nb * 8);
        if (nb == 4) begin
            push_word(word);
            push_word(32'h8000_0000);
        end else begin
            keep = (nb == 0) ? 32'd0 : (32'hffff_ffff << (32 - 8 * nb));
            push_word((word & keep) | (32'h80 << (24 - 8 * nb)));
        end
        // no room for the length: close this block with zeros first
        if (fill_count > 4'd14) begin
            while (fill_count != 4'd0)
                push_word(32'd0);
        end
        while (fill_count < 4'd14)
            push_word(32'd0);
        push_word(bit_len[63:32]);
        push_word(bit_len[31:0]);
        for (k = 0; k < 8; k++) begin
            beat.word  = chain_h[k];
            beat.index = 3'(k);
            beat.last  = (k == 7);
            expected_digest_q.push_back(beat);
        end
        restart_message();
    endfunction

    always @(posedge i_clk) begin : monitor
        t_digest_beat want;
        if (!i_rst_n) begin
            restart_message();
            expected_digest_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_digest_q.size() == 0) begin
                    errs++;
                    $display("%0t extra beat: expected none, got %h/%0d/%0b",
                             $time, i_digest_word, i_digest_index, i_digest_last);
                end else begin
                    want = expected_digest_q.pop_front();
                    checked++;
                    if (want.word !== i_digest_word || want.index !== i_digest_index ||
                        want.last !== i_digest_last) begin
                        errs++;
                        $display("%0t digest beat: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 $time, want.word, want.index, want.last,
                                 i_digest_word, i_digest_index, i_digest_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_word(i_message_word, i_valid_bytes, i_last_word);
        end
        o_mismatches <= errs;
        o_digests_pending <= expected_digest_q.size();
        o_digests_checked <= checked;
    end

endmodule
`default_nettype wire

/* dv/tb_sha256_stream_hasher_top.sv */
`default_nettype none
module tb_sha256_stream_hasher_top;
    import shs_pkg::*;

    localparam int WORD_TARGET  = 460;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        word_valid = 1'b0;
    logic        word_ready;
    t_word       message_word = '0;
    logic [2:0]  valid_bytes = '0;
    logic        last_word = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    t_word       digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    int mismatches;
    int digests_pending;
    int digests_checked;

    int words_sent = 0;
    int messages_sent = 0;
    int longest_message = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int idle_cycles = 0;

    sha256_stream_hasher_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_valid        (word_valid),
        .o_ready        (word_ready),
        .i_message_word (message_word),
        .i_valid_bytes  (valid_bytes),
        .i_last_word    (last_word),
        .o_valid        (digest_valid),
        .i_ready        (digest_ready),
        .o_digest_word  (digest_word),
        .o_digest_index (digest_index),
        .o_digest_last  (digest_last)
    );

    sha256_stream_hasher_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (word_valid),
        .i_in_ready        (word_ready),
        .i_message_word    (message_word),
        .i_valid_bytes     (valid_bytes),
        .i_last_word       (last_word),
        .i_out_valid       (digest_valid),
        .i_out_ready       (digest_ready),
        .i_digest_word     (digest_word),
        .i_digest_index    (digest_index),
        .i_digest_last     (digest_last),
        .o_mismatches      (mismatches),
        .o_digests_pending (digests_pending),
        .o_digests_checked (digests_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    // Wait before a beat, drawn at random, with runs of back-to-back beats.
    function automatic int draw_wait(inout int calm_left);
        int n;
        if (calm_left > 0) begin
            calm_left--;
            n = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(8, 30);
            n = 0;
        end else begin
            n = $urandom_range(0, 16);
        end
        return n;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input t_word w, input logic [2:0] vb, input logic last);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_valid   <= 1'b1;
        message_word <= w;
        valid_bytes  <= vb;
        last_word    <= last;
        do @(posedge i_clk); while (!word_ready);
        words_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic wait_digests_drained();
        word_valid <= 1'b0;
        do @(posedge i_clk); while (digests_pending != 0);
    endtask

    task automatic send_random_message();
        int         len;
        int         k;
        logic       noisy;
        logic [2:0] vb;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(0, 15);
            4, 5, 6:    len = $urandom_range(13, 17);
            7, 8:       len = $urandom_range(16, 40);
            default:    len = $urandom_range(40, 70);
        endcase
        // noisy messages carry random byte counts on words that are not last
        noisy = ($urandom_range(0, 7) == 0);
        for (k = 0; k < len; k++) begin
            vb = noisy ? 3'($urandom_range(0, 7)) : FULL_BYTES;
            send_beat(rand_word(), vb, 1'b0);
        end
        vb = $urandom_range(0, 1) ? FULL_BYTES : 3'($urandom_range(0, 7));
        send_beat(rand_word(), vb, 1'b1);
        if (len + 1 > longest_message)
            longest_message = len + 1;
    endtask

    // Output side: per-beat stall, ready held high until a beat goes through.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                digest_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            digest_ready <= 1'b1;
            do @(posedge i_clk); while (!digest_valid);
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((word_valid && word_ready) || (digest_valid && digest_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int k;
        wait (rst_n === 1'b1);
        @(posedge i_clk);

        // empty message; garbage below the count must be dropped
        send_beat(32'hdead_beef, 3'd0, 1'b1);
        // "abc" with a dirty low byte
        send_beat(32'h6162_63a5, 3'd3, 1'b1);
        send_beat(32'hffff_ffff, FULL_BYTES, 1'b1);
        // byte counts above four saturate on the last word
        send_beat(32'h0000_0000, 3'd5, 1'b1);
        send_beat(32'h8421_7ffe, 3'd6, 1'b1);
        send_beat(32'hffff_ffff, 3'd7, 1'b1);
        // short count on a non-final word is ignored, then an empty final word
        send_beat(32'h0123_4567, 3'd1, 1'b0);
        send_beat(32'hcafe_f00d, 3'd0, 1'b1);
        // full final word at position 14: length needs an extra block
        for (k = 0; k < 14; k++)
            send_beat((k % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, FULL_BYTES, 1'b0);
        send_beat(32'h5a5a_a5a5, FULL_BYTES, 1'b1);
        wait_digests_drained();

        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 5) == 0)
                wait_digests_drained();
            send_random_message();
        end
        word_valid <= 1'b0;

        do @(posedge i_clk); while (digests_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d words (longest %0d), %0d digest beats compared",
                 messages_sent, words_sent, longest_message, digests_checked);
        $display("final-word byte counts 0..7, short inner-word counts, block-edge padding");
        if (mismatches == 0 && digests_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
